// ===== sv/rms_pkg.sv =====
// Shared types and constants for the robot mode supervisor.
// Holds the request and result payloads, mode and event codes and the register map.
// No dependencies; every other file imports this package.
package rms_pkg;

  // Encoded mode numbers as they appear in the result.
  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_LISTEN = 3'd1;
  localparam logic [2:0] MODE_THINK  = 3'd2;
  localparam logic [2:0] MODE_ANSWER = 3'd3;
  localparam logic [2:0] MODE_HAPPY  = 3'd4;
  localparam logic [2:0] MODE_WARN   = 3'd5;
  localparam logic [2:0] MODE_ERROR  = 3'd6;
  localparam logic [2:0] MODE_SLEEP  = 3'd7;

  // Request kinds.
  localparam logic REQ_EVENT = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // Emotion values carried by an emotion change event.
  localparam logic [1:0] EMO_HAPPY = 2'd1;
  localparam logic [1:0] EMO_ERROR = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_ERROR_RECOVER   = 3'd0;
  localparam logic [2:0] CFG_HAPPY_RECOVER   = 3'd1;
  localparam logic [2:0] CFG_WARNING_RECOVER = 3'd2;
  localparam logic [2:0] CFG_IDLE_SLEEP      = 3'd3;
  localparam logic [2:0] CFG_SLEEP_WAKE      = 3'd4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Supervisor state, one-hot.
  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_LISTEN = 8'b0000_0010,
    ST_THINK  = 8'b0000_0100,
    ST_ANSWER = 8'b0000_1000,
    ST_HAPPY  = 8'b0001_0000,
    ST_WARN   = 8'b0010_0000,
    ST_ERROR  = 8'b0100_0000,
    ST_SLEEP  = 8'b1000_0000
  } state_t;

  // Event codes.
  typedef enum logic [3:0] {
    EV_LINK_UP       = 4'd0,
    EV_LINK_DOWN     = 4'd1,
    EV_LOW_BATT      = 4'd2,
    EV_CRIT_BATT     = 4'd3,
    EV_CAPTURE_START = 4'd4,
    EV_CAPTURE_STOP  = 4'd5,
    EV_PLAY_START    = 4'd6,
    EV_PLAY_DONE     = 4'd7,
    EV_PLAY_STOP     = 4'd8,
    EV_PLAY_ERROR    = 4'd9,
    EV_LLM_REPLY     = 4'd10,
    EV_CLOUD_ERROR   = 4'd11,
    EV_OBSTACLE      = 4'd12,
    EV_EDGE          = 4'd13,
    EV_FALL          = 4'd14,
    EV_EMOTION       = 4'd15
  } ev_code_t;

  // Request payload.
  typedef struct packed {
    logic       req_type;
    logic [3:0] event_code;
    logic       has_payload;
    logic [1:0] payload_emotion;
  } req_t;

  // Result payload.
  typedef struct packed {
    logic [2:0] mode;
    logic [1:0] mode_changes;
    logic       motor_halt;
    logic       link_up;
  } res_t;

  // Timeout thresholds as seen by the next-state logic.
  typedef struct packed {
    logic [CFG_DATA_W-1:0] error_recover_ms;
    logic [CFG_DATA_W-1:0] happy_recover_ms;
    logic [CFG_DATA_W-1:0] warning_recover_ms;
    logic [CFG_DATA_W-1:0] idle_sleep_ms;
    logic [CFG_DATA_W-1:0] sleep_wake_ms;
  } cfg_t;

  // One-hot state to the encoded mode number.
  function automatic logic [2:0] mode_code(input state_t st);
    logic [2:0] code;
    unique case (st)
      ST_IDLE:   code = MODE_IDLE;
      ST_LISTEN: code = MODE_LISTEN;
      ST_THINK:  code = MODE_THINK;
      ST_ANSWER: code = MODE_ANSWER;
      ST_HAPPY:  code = MODE_HAPPY;
      ST_WARN:   code = MODE_WARN;
      ST_ERROR:  code = MODE_ERROR;
      ST_SLEEP:  code = MODE_SLEEP;
      default:   code = MODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

// ===== sv/rms_cfg.sv =====
// Configuration register bank of the robot mode supervisor.
// Five 32-bit timeout thresholds written through a plain write port; uses rms_pkg.
module rms_cfg
  import rms_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  // Registers load their documented defaults on reset; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.error_recover_ms   <= CFG_DATA_W'(5000);
      cfg.happy_recover_ms   <= CFG_DATA_W'(3000);
      cfg.warning_recover_ms <= CFG_DATA_W'(3000);
      cfg.idle_sleep_ms      <= CFG_DATA_W'(300000);
      cfg.sleep_wake_ms      <= CFG_DATA_W'(1000);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ERROR_RECOVER:   cfg.error_recover_ms   <= cfg_data;
        CFG_HAPPY_RECOVER:   cfg.happy_recover_ms   <= cfg_data;
        CFG_WARNING_RECOVER: cfg.warning_recover_ms <= cfg_data;
        CFG_IDLE_SLEEP:      cfg.idle_sleep_ms      <= cfg_data;
        CFG_SLEEP_WAKE:      cfg.sleep_wake_ms      <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/rms_step.sv =====
// Next-state logic of the robot mode supervisor for one request.
// Applies the event table or the tick, then the timeout checks in order; uses rms_pkg.
module rms_step
  import rms_pkg::*;
#(
  parameter int TIMER_BITS = 32
) (
  input  req_t                  req,
  input  cfg_t                  cfg,
  input  state_t                cur_mode,
  input  logic [TIMER_BITS-1:0] cur_elapsed,
  input  logic [TIMER_BITS-1:0] cur_inactive,
  input  logic                  cur_link,
  output state_t                nxt_mode,
  output logic [TIMER_BITS-1:0] nxt_elapsed,
  output logic [TIMER_BITS-1:0] nxt_inactive,
  output logic                  nxt_link,
  output res_t                  res
);

  localparam int CMP_W = (TIMER_BITS > CFG_DATA_W) ? TIMER_BITS : CFG_DATA_W;

  // Event or tick phase, then the five timeout checks run one after another.
  always_comb begin
    state_t                go_tgt;
    logic                  go_en;
    logic                  estop;
    logic [1:0]            cnt;
    logic [CMP_W-1:0]      dur;
    logic [CMP_W-1:0]      ina;
    state_t                st;
    logic [TIMER_BITS-1:0] el;
    logic [TIMER_BITS-1:0] inact;
    logic                  lk;

    st     = cur_mode;
    el     = cur_elapsed;
    inact  = cur_inactive;
    lk     = cur_link;
    cnt    = 2'd0;
    estop  = 1'b0;
    go_en  = 1'b0;
    go_tgt = cur_mode;

    if (req.req_type == REQ_TICK) begin
      // Both timers count milliseconds and saturate at all ones.
      if (el != '1) el = el + TIMER_BITS'(1);
      if (inact != '1) inact = inact + TIMER_BITS'(1);
    end else begin
      inact = '0;
      unique case (ev_code_t'(req.event_code))
        EV_LINK_UP: begin
          lk     = 1'b1;
          go_en  = (st == ST_ERROR);
          go_tgt = ST_IDLE;
        end
        EV_LINK_DOWN: lk = 1'b0;
        EV_LOW_BATT: begin
          go_en  = 1'b1;
          go_tgt = ST_WARN;
        end
        EV_CRIT_BATT: begin
          go_en  = 1'b1;
          go_tgt = ST_SLEEP;
        end
        EV_CAPTURE_START: begin
          go_en  = 1'b1;
          go_tgt = ST_LISTEN;
        end
        EV_CAPTURE_STOP: begin
          go_en  = (st == ST_LISTEN);
          go_tgt = ST_THINK;
        end
        EV_PLAY_START: begin
          go_en  = 1'b1;
          go_tgt = ST_ANSWER;
        end
        EV_PLAY_DONE, EV_PLAY_STOP: begin
          go_en  = (st == ST_ANSWER);
          go_tgt = ST_IDLE;
        end
        EV_PLAY_ERROR: begin
          go_en  = (st == ST_ANSWER);
          go_tgt = ST_ERROR;
        end
        EV_CLOUD_ERROR: begin
          go_en  = (st == ST_THINK);
          go_tgt = ST_ERROR;
        end
        EV_OBSTACLE, EV_EDGE: begin
          go_en  = 1'b1;
          go_tgt = ST_WARN;
          estop  = 1'b1;
        end
        EV_FALL: begin
          go_en  = 1'b1;
          go_tgt = ST_ERROR;
        end
        EV_EMOTION: begin
          go_en  = req.has_payload &&
                   (req.payload_emotion == EMO_HAPPY || req.payload_emotion == EMO_ERROR);
          go_tgt = (req.payload_emotion == EMO_HAPPY) ? ST_HAPPY : ST_ERROR;
        end
        default: ;
      endcase
      // A move to the mode already held is not a change and keeps the timer.
      if (go_en && go_tgt != st) begin
        st  = go_tgt;
        el  = '0;
        cnt = cnt + 2'd1;
      end
    end

    // The recovery checks all compare the mode time taken before any of them.
    dur = CMP_W'(el);
    ina = CMP_W'(inact);

    if (st == ST_ERROR && dur > CMP_W'(cfg.error_recover_ms)) begin
      st  = ST_IDLE;
      el  = '0;
      cnt = cnt + 2'd1;
    end
    if (st == ST_HAPPY && dur > CMP_W'(cfg.happy_recover_ms)) begin
      st  = ST_IDLE;
      el  = '0;
      cnt = cnt + 2'd1;
    end
    if (st == ST_WARN && dur > CMP_W'(cfg.warning_recover_ms)) begin
      st  = ST_IDLE;
      el  = '0;
      cnt = cnt + 2'd1;
    end
    if (st == ST_IDLE && ina > CMP_W'(cfg.idle_sleep_ms)) begin
      st  = ST_SLEEP;
      el  = '0;
      cnt = cnt + 2'd1;
    end
    if (st == ST_SLEEP && ina < CMP_W'(cfg.sleep_wake_ms)) begin
      st  = ST_IDLE;
      el  = '0;
      cnt = cnt + 2'd1;
    end

    nxt_mode         = st;
    nxt_elapsed      = el;
    nxt_inactive     = inact;
    nxt_link         = lk;
    res.mode         = mode_code(st);
    res.mode_changes = cnt;
    res.motor_halt   = estop;
    res.link_up      = lk;
  end

endmodule

// ===== sv/robot_mode_supervisor_fsm_top.sv =====
// Robot mode supervisor: one request in, one result out; a request can be accepted
// in every clock cycle while the result channel is not stalled. A request sits in
// the input register while the combinational next-state logic updates the mode,
// timers and link flag and loads the result register, from which the result is
// offered. A stalled result holds the pipeline; the input register then holds the
// next request and raises req_stall.
// Configuration registers may be written at any time the block is idle.
//
// Top level: input register, supervisor state, result register; uses rms_pkg,
// rms_cfg and rms_step.
module robot_mode_supervisor_fsm_top
  import rms_pkg::*;
#(
  parameter int TIMER_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  req_t                  req_data,
  output logic                  res_valid,
  input  logic                  res_stall,
  output res_t                  res_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t                  cfg;
  req_t                  req_q;
  logic                  req_q_valid;
  logic                  advance;
  state_t                cur_mode;
  logic [TIMER_BITS-1:0] mode_elapsed_ms;
  logic [TIMER_BITS-1:0] inactive_ms;
  logic                  link_flag;
  state_t                mode_next;
  logic [TIMER_BITS-1:0] mode_elapsed_ms_next;
  logic [TIMER_BITS-1:0] inactive_ms_next;
  logic                  link_flag_next;
  res_t                  res_next;

  rms_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rms_step #(
    .TIMER_BITS (TIMER_BITS)
  ) u_step (
    .req          (req_q),
    .cfg          (cfg),
    .cur_mode     (cur_mode),
    .cur_elapsed  (mode_elapsed_ms),
    .cur_inactive (inactive_ms),
    .cur_link     (link_flag),
    .nxt_mode     (mode_next),
    .nxt_elapsed  (mode_elapsed_ms_next),
    .nxt_inactive (inactive_ms_next),
    .nxt_link     (link_flag_next),
    .res          (res_next)
  );

  // The held request is processed once the result register has room.
  assign advance   = req_q_valid && (!res_valid || !res_stall);
  assign req_stall = req_q_valid && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_q_valid <= 1'b0;
    end else if (!req_stall) begin
      req_q_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall && req_valid) begin
      req_q <= req_data;
    end
  end

  // Supervisor state moves on exactly when a request is processed.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mode        <= ST_IDLE;
      mode_elapsed_ms <= '0;
      inactive_ms     <= '0;
      link_flag       <= 1'b0;
    end else if (advance) begin
      cur_mode        <= mode_next;
      mode_elapsed_ms <= mode_elapsed_ms_next;
      inactive_ms     <= inactive_ms_next;
      link_flag       <= link_flag_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_data <= res_next;
    end
  end

endmodule

// ===== sv/rms_checker.sv =====
// Port-level checks for the robot mode supervisor, bound to the top level.
// Watches the result channel only; uses rms_pkg.
module rms_checker
  import rms_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic res_valid,
  input logic res_stall,
  input res_t res_data
);

  logic       res_take;
  logic [2:0] last_mode;

  assign res_take = res_valid && !res_stall;

  // Mode reported by the most recent delivered result; idle out of reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_mode <= MODE_IDLE;
    end else if (res_take) begin
      last_mode <= res_data.mode;
    end
  end

  // A stalled result stays offered and unchanged.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_data))
    else $error("result changed or dropped while stalled");

  // A motor halt lands the supervisor in warning mode, or in idle when a warning
  // already held past a lowered recovery time ends at once.
  a_estop_warn: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.motor_halt |->
      (res_data.mode == MODE_WARN || res_data.mode == MODE_IDLE))
    else $error("motor halt reported outside warning or idle mode");

  // A request with no transition leaves the mode as the previous result showed.
  a_no_change_same_mode: assert property (@(posedge clk) disable iff (rst)
    res_take && res_data.mode_changes == 2'd0 |-> res_data.mode == last_mode)
    else $error("mode moved without a reported transition");

endmodule

bind robot_mode_supervisor_fsm_top rms_checker u_rms_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_data  (res_data)
);

// ===== test/robot_mode_supervisor_fsm_top_tb.sv =====
// Self-checking testbench for the robot mode supervisor top level.
// Predicts every result from its own copy of the mode, timers and thresholds.
// Depends on rms_pkg and robot_mode_supervisor_fsm_top only.
module robot_mode_supervisor_fsm_top_tb;
  import rms_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Timer width used for the block under test.
  localparam int TIMER_W = 16;
  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;
  localparam int WATCHDOG_CYCLES = 3000;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES = 5;
  localparam int MAX_REPORTS = 40;

  // Receiver stall styles.
  localparam int STALL_NONE   = 0;
  localparam int STALL_RANDOM = 1;
  localparam int STALL_RUNS   = 2;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req_data = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predicted supervisor state and thresholds.
  logic [2:0] sv_mode = MODE_IDLE;
  logic [TIMER_W-1:0] mode_age_ms = '0;
  logic [TIMER_W-1:0] idle_age_ms = '0;
  logic link_on = 1'b0;
  int unsigned mode_hops;
  logic [CFG_DATA_W-1:0] thr [5] = '{32'd5000, 32'd3000, 32'd3000, 32'd300000, 32'd1000};

  res_t expected_status [$];
  res_t want;
  int mismatches = 0;

  // Sender and receiver pacing.
  bit offering = 1'b0;
  bit gaps_on = 1'b1;
  int burst_left = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int stall_style = STALL_NONE;
  int style_left = 0;
  int run_left = 0;
  bit run_stalled = 1'b0;
  int quiet_cycles = 0;

  robot_mode_supervisor_fsm_top #(.TIMER_BITS(TIMER_W)) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data(req_data),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_data(res_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Mode change in the predictor; re-entering the current mode keeps the timer.
  function automatic void switch_mode(input logic [2:0] m);
    if (m != sv_mode) begin
      sv_mode = m;
      mode_age_ms = '0;
      mode_hops++;
    end
  endfunction

  // Applies one request to the predicted state and returns the status it leads to.
  function automatic res_t step_supervisor(input req_t r);
    res_t st;
    logic stop;
    logic [TIMER_W-1:0] dur;
    stop = 1'b0;
    mode_hops = 0;
    if (r.req_type == REQ_TICK) begin
      if (mode_age_ms != TIMER_MAX) mode_age_ms++;
      if (idle_age_ms != TIMER_MAX) idle_age_ms++;
    end else begin
      idle_age_ms = '0;
      case (ev_code_t'(r.event_code))
        EV_LINK_UP: begin
          link_on = 1'b1;
          if (sv_mode == MODE_ERROR) switch_mode(MODE_IDLE);
        end
        EV_LINK_DOWN:     link_on = 1'b0;
        EV_LOW_BATT:      switch_mode(MODE_WARN);
        EV_CRIT_BATT:     switch_mode(MODE_SLEEP);
        EV_CAPTURE_START: switch_mode(MODE_LISTEN);
        EV_CAPTURE_STOP: begin
          if (sv_mode == MODE_LISTEN) switch_mode(MODE_THINK);
        end
        EV_PLAY_START:    switch_mode(MODE_ANSWER);
        EV_PLAY_DONE, EV_PLAY_STOP: begin
          if (sv_mode == MODE_ANSWER) switch_mode(MODE_IDLE);
        end
        EV_PLAY_ERROR: begin
          if (sv_mode == MODE_ANSWER) switch_mode(MODE_ERROR);
        end
        EV_CLOUD_ERROR: begin
          if (sv_mode == MODE_THINK) switch_mode(MODE_ERROR);
        end
        EV_OBSTACLE, EV_EDGE: begin
          switch_mode(MODE_WARN);
          stop = 1'b1;
        end
        EV_FALL:          switch_mode(MODE_ERROR);
        EV_EMOTION: begin
          if (r.has_payload) begin
            if (r.payload_emotion == EMO_HAPPY) switch_mode(MODE_HAPPY);
            else if (r.payload_emotion == EMO_ERROR) switch_mode(MODE_ERROR);
          end
        end
        default: ;
      endcase
    end
    // Timeout checks run once each, in this order.
    dur = mode_age_ms;
    if (sv_mode == MODE_ERROR && dur > thr[CFG_ERROR_RECOVER]) switch_mode(MODE_IDLE);
    if (sv_mode == MODE_HAPPY && dur > thr[CFG_HAPPY_RECOVER]) switch_mode(MODE_IDLE);
    if (sv_mode == MODE_WARN && dur > thr[CFG_WARNING_RECOVER]) switch_mode(MODE_IDLE);
    if (sv_mode == MODE_IDLE && idle_age_ms > thr[CFG_IDLE_SLEEP]) switch_mode(MODE_SLEEP);
    if (sv_mode == MODE_SLEEP && idle_age_ms < thr[CFG_SLEEP_WAKE]) switch_mode(MODE_IDLE);
    st.mode = sv_mode;
    st.mode_changes = mode_hops[1:0];
    st.motor_halt = stop;
    st.link_up = link_on;
    return st;
  endfunction

  // A tick with random bits in the fields it ignores.
  function automatic req_t make_tick();
    req_t r;
    r.req_type = REQ_TICK;
    r.event_code = 4'($urandom_range(0, 15));
    r.has_payload = 1'($urandom_range(0, 1));
    r.payload_emotion = 2'($urandom_range(0, 3));
    return r;
  endfunction

  function automatic req_t make_event(input ev_code_t c, input logic pl,
                                      input logic [1:0] emo);
    req_t r;
    r.req_type = REQ_EVENT;
    r.event_code = c;
    r.has_payload = pl;
    r.payload_emotion = emo;
    return r;
  endfunction

  // Random traffic: mostly ticks and conversation-shaped events, some noise.
  function automatic req_t pick_request();
    req_t r;
    int roll;
    roll = $urandom_range(0, 99);
    r = make_tick();
    if (roll < 45) return r;
    r.req_type = REQ_EVENT;
    if (roll < 75) begin
      case (sv_mode)
        MODE_IDLE:   r.event_code = EV_CAPTURE_START;
        MODE_LISTEN: r.event_code = EV_CAPTURE_STOP;
        MODE_THINK: begin
          if ($urandom_range(0, 7) == 0) r.event_code = EV_CLOUD_ERROR;
          else if ($urandom_range(0, 1) == 0) r.event_code = EV_LLM_REPLY;
          else r.event_code = EV_PLAY_START;
        end
        MODE_ANSWER: begin
          case ($urandom_range(0, 3))
            0: r.event_code = EV_PLAY_ERROR;
            1: r.event_code = EV_PLAY_STOP;
            default: r.event_code = EV_PLAY_DONE;
          endcase
        end
        default: r.event_code = $urandom_range(0, 1) ? EV_LINK_UP : EV_CAPTURE_START;
      endcase
    end else if (roll < 85) begin
      r.event_code = EV_EMOTION;
    end
    return r;
  endfunction

  // Mostly small thresholds so that timeouts fire often, now and then a wide one.
  function automatic logic [CFG_DATA_W-1:0] rand_threshold();
    if ($urandom_range(0, 5) == 0) return $urandom;
    return $urandom_range(0, 12);
  endfunction

  // Offers one request, waits for it to be taken, then maybe pauses.
  task automatic send_request(input req_t r);
    int gap;
    req_valid <= 1'b1;
    req_data <= r;
    offering = 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    expected_status.push_back(step_supervisor(r));
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 12);
        req_valid <= 1'b0;
        offering = 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Stops offering and waits until every predicted result has come back.
  task automatic wait_drained();
    if (offering) begin
      req_valid <= 1'b0;
      offering = 1'b0;
    end
    while (expected_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    thr[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_thresholds(input logic [CFG_DATA_W-1:0] err, happy, warn, nap, wake);
    write_reg(CFG_ERROR_RECOVER, err);
    write_reg(CFG_HAPPY_RECOVER, happy);
    write_reg(CFG_WARNING_RECOVER, warn);
    write_reg(CFG_IDLE_SLEEP, nap);
    write_reg(CFG_SLEEP_WAKE, wake);
  endtask

  // Every event code under the reset thresholds, including the corner cases.
  task automatic test_event_table();
    send_request(make_event(EV_LINK_UP, 1'b1, 2'd3));
    send_request(make_event(EV_CAPTURE_START, 1'b0, 2'd0));
    send_request(make_event(EV_CAPTURE_START, 1'b0, 2'd0));
    send_request(make_event(EV_CAPTURE_STOP, 1'b0, 2'd0));
    send_request(make_event(EV_LLM_REPLY, 1'b1, 2'd1));
    send_request(make_event(EV_CLOUD_ERROR, 1'b0, 2'd0));
    send_request(make_tick());
    send_request(make_event(EV_LINK_UP, 1'b0, 2'd0));
    send_request(make_event(EV_PLAY_START, 1'b0, 2'd0));
    send_request(make_event(EV_PLAY_ERROR, 1'b0, 2'd0));
    send_request(make_event(EV_FALL, 1'b0, 2'd2));
    send_request(make_event(EV_PLAY_START, 1'b0, 2'd0));
    send_request(make_event(EV_PLAY_DONE, 1'b0, 2'd0));
    send_request(make_event(EV_PLAY_START, 1'b0, 2'd0));
    send_request(make_event(EV_PLAY_STOP, 1'b0, 2'd0));
    send_request(make_event(EV_EMOTION, 1'b0, EMO_HAPPY));
    send_request(make_event(EV_EMOTION, 1'b1, EMO_HAPPY));
    send_request(make_event(EV_EMOTION, 1'b1, 2'd3));
    send_request(make_event(EV_EMOTION, 1'b1, EMO_ERROR));
    send_request(make_event(EV_LOW_BATT, 1'b0, 2'd0));
    send_request(make_event(EV_OBSTACLE, 1'b0, 2'd0));
    send_request(make_event(EV_EDGE, 1'b1, 2'd1));
    send_request(make_event(EV_LINK_DOWN, 1'b0, 2'd0));
    send_request(make_event(EV_CRIT_BATT, 1'b0, 2'd0));
    send_request(make_event(EV_CAPTURE_STOP, 1'b0, 2'd0));
    wait_drained();
  endtask

  // Short thresholds: recoveries, sleep entry and wake, and a triple change.
  task automatic test_timeouts();
    set_thresholds(32'd3, 32'd2, 32'd0, 32'd0, 32'd10);
    send_request(make_event(EV_LOW_BATT, 1'b0, 2'd0));
    send_request(make_tick());
    send_request(make_event(EV_FALL, 1'b0, 2'd0));
    repeat (5) send_request(make_tick());
    send_request(make_event(EV_EMOTION, 1'b1, EMO_HAPPY));
    repeat (4) send_request(make_tick());
    wait_drained();
    write_reg(CFG_IDLE_SLEEP, 32'd3);
    write_reg(CFG_SLEEP_WAKE, 32'd2);
    repeat (6) send_request(make_tick());
    send_request(make_event(EV_LINK_UP, 1'b0, 2'd0));
    wait_drained();
    // With no wake window, critical battery stays asleep.
    write_reg(CFG_SLEEP_WAKE, 32'd0);
    send_request(make_event(EV_CRIT_BATT, 1'b0, 2'd0));
    send_request(make_tick());
    wait_drained();
  endtask

  // Random traffic over several threshold settings, the extremes first.
  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      wait_drained();
      case (phase)
        0: set_thresholds('0, '0, '0, '0, '0);
        1: set_thresholds('1, '1, '1, '1, '1);
        default: set_thresholds(rand_threshold(), rand_threshold(), rand_threshold(),
                                rand_threshold(), rand_threshold());
      endcase
      gaps_on = (phase != 2);
      repeat (130) send_request(pick_request());
    end
    wait_drained();
  endtask

  // The receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_req = 1'b1;
    repeat (40) send_request(pick_request());
    wait_drained();
    gaps_on = 1'b1;
  endtask

  // Receiver stall pattern, with a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (hold_left > 0) begin
      res_stall <= 1'b1;
      hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
      res_stall <= 1'b1;
    end else begin
      if (style_left == 0) begin
        stall_style = $urandom_range(STALL_NONE, STALL_RUNS);
        style_left = $urandom_range(50, 400);
      end else begin
        style_left--;
      end
      case (stall_style)
        STALL_NONE:   res_stall <= 1'b0;
        STALL_RANDOM: res_stall <= ($urandom_range(0, 3) == 0);
        default: begin
          if (run_left == 0) begin
            run_stalled = !run_stalled;
            run_left = $urandom_range(1, 8);
          end else begin
            run_left--;
          end
          res_stall <= run_stalled;
        end
      endcase
    end
  end

  function automatic void flag_mismatch(input string what, input logic [2:0] exp_v,
                                        input logic [2:0] got_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, got_v);
  endfunction

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (expected_status.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result expected none, got %h", $time, res_data);
      end else begin
        want = expected_status.pop_front();
        if (res_data.mode !== want.mode) flag_mismatch("mode", want.mode, res_data.mode);
        if (res_data.mode_changes !== want.mode_changes)
          flag_mismatch("mode_changes", 3'(want.mode_changes), 3'(res_data.mode_changes));
        if (res_data.motor_halt !== want.motor_halt)
          flag_mismatch("motor_halt", 3'(want.motor_halt), 3'(res_data.motor_halt));
        if (res_data.link_up !== want.link_up)
          flag_mismatch("link_up", 3'(want.link_up), 3'(res_data.link_up));
      end
    end
  end

  // Watchdog: ends the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst || cfg_we || (req_valid && !req_stall) || (res_valid && !res_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_event_table();
    test_timeouts();
    test_random_traffic();
    test_backpressure();
    wait_drained();
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
